/* src/rotated_window_page_sequencer_macros.svh */
// Assertion macros used by the page sequencer top level.
`ifndef ROTATED_WINDOW_PAGE_SEQUENCER_MACROS_SVH
`define ROTATED_WINDOW_PAGE_SEQUENCER_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RWPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define RWPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/rwps_pkg.sv */
// Types, constants and helper functions of the rotated window page sequencer.
`default_nettype none

package rwps_pkg;

    localparam int COORD_BITS  = 9;
    localparam int ROW_BITS    = COORD_BITS + 1;
    localparam int SW          = COORD_BITS + 3;
    localparam int BYTE_SHIFT  = 3;
    localparam int BYTE_PIXELS = 8;
    localparam int SPAN_BITS   = ROW_BITS - BYTE_SHIFT;
    localparam int BYTES_BITS  = 16;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [ROW_BITS-1:0]   row_t;
    typedef logic [SPAN_BITS-1:0]  span_t;
    typedef logic [BYTES_BITS-1:0] bytes_t;
    typedef logic signed [SW-1:0]  sval_t;

    typedef enum logic [1:0] {
        REG_PANEL_WIDTH  = 2'd0,
        REG_PANEL_HEIGHT = 2'd1,
        REG_ROTATION     = 2'd2,
        REG_PAGE_ROWS    = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rot_t;

    localparam coord_t PANEL_WIDTH_RESET  = coord_t'(128);
    localparam coord_t PANEL_HEIGHT_RESET = coord_t'(296);
    localparam rot_t   ROTATION_RESET     = ROT_0;
    localparam coord_t PAGE_ROWS_RESET    = coord_t'(20);

    localparam sval_t ONE        = sval_t'(1);
    localparam sval_t BYTE_ROUND = sval_t'(BYTE_PIXELS - 1);

    typedef struct packed {
        logic   fullscreen;
        coord_t win_left;
        coord_t win_top;
        coord_t win_width;
        coord_t win_height;
    } call_t;

    typedef struct packed {
        logic   pass_started;
        logic   send_previous;
        logic   keep_going;
        row_t   page_first_row;
        row_t   page_end_row;
        row_t   column_start;
        row_t   column_end;
        bytes_t page_bytes;
    } page_t;

    typedef struct packed {
        row_t left;
        row_t right;
        row_t top;
        row_t bottom;
    } window_t;

    typedef struct packed {
        coord_t panel_width;
        coord_t panel_height;
        rot_t   rotation;
    } panel_cfg_t;

    function automatic sval_t widen(coord_t c);
        return $signed({{(SW - COORD_BITS){1'b0}}, c});
    endfunction

    function automatic sval_t sat0(sval_t v);
        return v[SW-1] ? '0 : v;
    endfunction

    function automatic sval_t floor8(sval_t v);
        sval_t s;
        s = sat0(v);
        return $signed({s[SW-1:BYTE_SHIFT], {BYTE_SHIFT{1'b0}}});
    endfunction

    function automatic sval_t ceil8(sval_t v);
        sval_t t;
        t = v + BYTE_ROUND;
        return $signed({t[SW-1:BYTE_SHIFT], {BYTE_SHIFT{1'b0}}});
    endfunction

    // The start is always a whole byte, so growing to the target is a byte ceiling.
    function automatic sval_t grow8(sval_t start, sval_t target);
        return (target > start) ? ceil8(target) : start;
    endfunction

    function automatic row_t to_row(sval_t v);
        sval_t s;
        s = sat0(v);
        return s[ROW_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

/* src/rwps_call_if.sv */
// Channel interface that carries one paging call.
`default_nettype none

interface rwps_call_if;
    logic           valid;
    logic           ready;
    rwps_pkg::call_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/rwps_page_if.sv */
// Channel interface that carries one page result.
`default_nettype none

interface rwps_page_if;
    logic           valid;
    logic           ready;
    rwps_pkg::page_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/rwps_window_map.sv */
// Clamps a drawing window to the panel and maps it into panel memory for the rotation.
`default_nettype none

module rwps_window_map
(
    input  wire rwps_pkg::panel_cfg_t cfg,
    input  wire rwps_pkg::call_t      call_item,
    output rwps_pkg::window_t         win
);

    rwps_pkg::sval_t pw;
    rwps_pkg::sval_t ph;
    rwps_pkg::sval_t wl;
    rwps_pkg::sval_t wt;
    rwps_pkg::sval_t wr_raw;
    rwps_pkg::sval_t wb_raw;
    rwps_pkg::sval_t ext_x;
    rwps_pkg::sval_t ext_y;
    rwps_pkg::sval_t wr;
    rwps_pkg::sval_t wb;
    rwps_pkg::sval_t l;
    rwps_pkg::sval_t r;
    rwps_pkg::sval_t t;
    rwps_pkg::sval_t b;
    rwps_pkg::sval_t l_far;
    logic            sideways;

    assign pw       = rwps_pkg::widen(cfg.panel_width);
    assign ph       = rwps_pkg::widen(cfg.panel_height);
    assign sideways = cfg.rotation[0];
    assign ext_x    = sideways ? ph : pw;
    assign ext_y    = sideways ? pw : ph;

    always_comb
    begin
        if (call_item.fullscreen)
        begin
            wl     = '0;
            wt     = '0;
            wr_raw = ext_x - rwps_pkg::ONE;
            wb_raw = ext_y - rwps_pkg::ONE;
        end
        else
        begin
            wl     = rwps_pkg::widen(call_item.win_left);
            wt     = rwps_pkg::widen(call_item.win_top);
            wr_raw = wl + rwps_pkg::widen(call_item.win_width) - rwps_pkg::ONE;
            wb_raw = wt + rwps_pkg::widen(call_item.win_height) - rwps_pkg::ONE;
        end
    end

    assign wr = (wr_raw > ext_x) ? ext_x : wr_raw;
    assign wb = (wb_raw > ext_y) ? ext_y : wb_raw;

    always_comb
    begin
        l_far = rwps_pkg::floor8(pw - wr - rwps_pkg::ONE);
        unique case (cfg.rotation)
            rwps_pkg::ROT_0:
            begin
                l = rwps_pkg::floor8(wl);
                r = rwps_pkg::grow8(l, wr);
                t = wt;
                b = wb + rwps_pkg::ONE;
            end
            rwps_pkg::ROT_90:
            begin
                l = rwps_pkg::floor8(pw - wb - rwps_pkg::ONE);
                r = rwps_pkg::grow8(l, pw - wt);
                t = wl;
                b = wr + rwps_pkg::ONE;
            end
            rwps_pkg::ROT_180:
            begin
                r = rwps_pkg::ceil8(rwps_pkg::sat0(pw - wl));
                l = (r < l_far) ? r : l_far;
                t = ph - wb - rwps_pkg::ONE;
                b = ph - wt;
            end
            rwps_pkg::ROT_270:
            begin
                l = rwps_pkg::floor8(wt);
                r = rwps_pkg::grow8(l, wb);
                t = ph - wr - rwps_pkg::ONE;
                b = ph - wl;
            end
        endcase
    end

    assign win.left   = rwps_pkg::to_row(l);
    assign win.right  = rwps_pkg::to_row(r);
    assign win.top    = rwps_pkg::to_row(t);
    assign win.bottom = rwps_pkg::to_row(b);

endmodule

`default_nettype wire

/* src/rotated_window_page_sequencer.sv */
// Top level of the rotated window page sequencer.
//
//   Channel  Carries                           Handshake
//   call     one paging call (window fields)   valid/ready, sink
//   page     one page result per call          valid/ready, source
//   cfg_*    panel size, rotation, page rows   write enable, no wait
//
// One transaction per cycle is sustained while the page channel is ready; each call takes three register stages.
// A taken call passes the entry, middle and output registers in turn before its result is presented.
// The window mapping is registered on entry, the page step and pass state update
// in the middle stage, and the byte-length multiply fills the output register.
// Reset clears the pass state and loads the default panel configuration.
// A stalled output holds its result while empty stages upstream keep filling.
`default_nettype none

module rotated_window_page_sequencer
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     cfg_we,
    input  wire rwps_pkg::cfg_reg_t cfg_index,
    input  wire rwps_pkg::coord_t   cfg_data,
    rwps_call_if.sink               call,
    rwps_page_if.source             page
);

`include "rotated_window_page_sequencer_macros.svh"

    rwps_pkg::coord_t   panel_width_reg;
    rwps_pkg::coord_t   panel_height_reg;
    rwps_pkg::rot_t     rotation_reg;
    rwps_pkg::coord_t   page_rows_reg;
    rwps_pkg::panel_cfg_t panel_cfg;

    rwps_pkg::window_t  call_win;
    logic               s1_valid_reg;
    rwps_pkg::window_t  s1_win_reg;

    logic               pass_active_reg;
    rwps_pkg::window_t  win_state_reg;
    rwps_pkg::row_t     cur_top_reg;
    rwps_pkg::row_t     cur_bot_reg;

    logic               s2_valid_reg;
    rwps_pkg::page_t    s2_page_reg;
    rwps_pkg::row_t     s2_rows_reg;
    rwps_pkg::span_t    s2_span_reg;

    logic               out_valid_reg;
    rwps_pkg::page_t    out_page_reg;

    logic               load1;
    logic               load2;
    logic               load3;
    logic               advance2;

    logic               use_new;
    rwps_pkg::window_t  win_cur;
    logic               send;
    rwps_pkg::row_t     top;
    logic [rwps_pkg::ROW_BITS:0] reach;
    rwps_pkg::row_t     bot;
    rwps_pkg::row_t     row_diff;
    rwps_pkg::row_t     rows_span;
    rwps_pkg::row_t     col_diff;
    logic               keep;
    rwps_pkg::page_t    s2_page_next;
    logic [rwps_pkg::ROW_BITS+rwps_pkg::SPAN_BITS-1:0] prod;
    rwps_pkg::page_t    out_page_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            panel_width_reg  <= rwps_pkg::PANEL_WIDTH_RESET;
            panel_height_reg <= rwps_pkg::PANEL_HEIGHT_RESET;
            rotation_reg     <= rwps_pkg::ROTATION_RESET;
            page_rows_reg    <= rwps_pkg::PAGE_ROWS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rwps_pkg::REG_PANEL_WIDTH:  panel_width_reg  <= cfg_data;
                rwps_pkg::REG_PANEL_HEIGHT: panel_height_reg <= cfg_data;
                rwps_pkg::REG_ROTATION:     rotation_reg     <= rwps_pkg::rot_t'(cfg_data[1:0]);
                rwps_pkg::REG_PAGE_ROWS:    page_rows_reg    <= cfg_data;
            endcase
        end
    end

    assign panel_cfg.panel_width  = panel_width_reg;
    assign panel_cfg.panel_height = panel_height_reg;
    assign panel_cfg.rotation     = rotation_reg;

    rwps_window_map u_window_map
    (
        .cfg       (panel_cfg),
        .call_item (call.data),
        .win       (call_win)
    );

    assign load3      = !out_valid_reg || page.ready;
    assign load2      = !s2_valid_reg || load3;
    assign call.ready = !s1_valid_reg || load2;
    assign load1      = call.valid && call.ready;
    assign advance2   = s1_valid_reg && load2;

    always_comb
    begin
        use_new   = !pass_active_reg;
        win_cur   = use_new ? s1_win_reg : win_state_reg;
        send      = !use_new && !(win_state_reg.bottom < cur_top_reg ||
                                  win_state_reg.top > cur_bot_reg);
        top       = use_new ? s1_win_reg.top : cur_top_reg + {1'b0, page_rows_reg};
        reach     = {1'b0, top} + {2'b00, page_rows_reg};
        bot       = (reach < {1'b0, win_cur.bottom}) ? reach[rwps_pkg::ROW_BITS-1:0]
                                                     : win_cur.bottom;
        row_diff  = bot - top;
        rows_span = (bot > top) ? row_diff : '0;
        col_diff  = win_cur.right - win_cur.left;
        keep      = top < win_cur.bottom;

        s2_page_next.pass_started   = use_new;
        s2_page_next.send_previous  = send;
        s2_page_next.keep_going     = keep;
        s2_page_next.page_first_row = top;
        s2_page_next.page_end_row   = bot;
        s2_page_next.column_start   = win_cur.left;
        s2_page_next.column_end     = win_cur.right;
        s2_page_next.page_bytes     = '0;
    end

    always_comb
    begin
        prod                     = s2_rows_reg * s2_span_reg;
        out_page_next            = s2_page_reg;
        out_page_next.page_bytes = rwps_pkg::bytes_t'(prod);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            pass_active_reg <= 1'b0;
            win_state_reg   <= '0;
            cur_top_reg     <= '0;
            cur_bot_reg     <= '0;
        end
        else
        begin
            if (call.ready)
            begin
                s1_valid_reg <= call.valid;
            end
            if (load2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (load3)
            begin
                out_valid_reg <= s2_valid_reg;
            end
            if (advance2)
            begin
                pass_active_reg <= keep;
                cur_top_reg     <= top;
                cur_bot_reg     <= bot;
                if (use_new)
                begin
                    win_state_reg <= s1_win_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            s1_win_reg <= call_win;
        end
        if (advance2)
        begin
            s2_page_reg <= s2_page_next;
            s2_rows_reg <= rows_span;
            s2_span_reg <= col_diff[rwps_pkg::ROW_BITS-1:rwps_pkg::BYTE_SHIFT];
        end
        if (load3 && s2_valid_reg)
        begin
            out_page_reg <= out_page_next;
        end
    end

    assign page.valid = out_valid_reg;
    assign page.data  = out_page_reg;

    `RWPS_ASSERT_NEXT(a_pass_end, clk, rst_n, advance2 && !keep, !pass_active_reg, "Pass state stayed active after the last page.")
    `RWPS_ASSERT_NEXT(a_window_latch, clk, rst_n, advance2 && use_new, win_state_reg == $past(s1_win_reg), "Window was not latched on the first call of a pass.")
    `RWPS_ASSERT_NOW(a_first_no_send, clk, rst_n, out_valid_reg && out_page_reg.pass_started, !out_page_reg.send_previous, "First call of a pass asked to send a page.")
    `RWPS_ASSERT_NOW(a_bytes_in_window, clk, rst_n, out_valid_reg && (out_page_reg.page_bytes != '0), out_page_reg.page_end_row > out_page_reg.page_first_row, "Nonzero byte length for an empty page.")
    `RWPS_ASSERT_NEXT(a_mid_stall_hold, clk, rst_n, s2_valid_reg && !load3, s2_valid_reg && $stable(s2_page_reg), "Middle stage lost its transaction during a stall.")

endmodule

`default_nettype wire
